/* sv/dbdc_pkg.sv */
// ----------------------------------------------------------------------------
// dbdc_pkg
// Types, codes and constants shared by the two-beam direction counter.
// ----------------------------------------------------------------------------
package dbdc_pkg;

   localparam int unsigned COUNT_WIDTH_DEF = 8;

   localparam logic [7:0]  LIMIT_RESET   = 8'd5;
   localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam logic        REG_LIMIT      = 1'b0;
   localparam logic        REG_TIMEOUT    = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_OUTER = 2'd1,
      PH_INNER = 2'd2,
      PH_CLEAR = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_ENTRY = 2'd1,
      EV_OVER  = 2'd2,
      EV_EXIT  = 2'd3
   } event_type;

   typedef struct packed {
      logic        command;
      logic        beam_a;
      logic        beam_b;
      logic [31:0] now_ms;
      logic [7:0]  preset_count;
   } req_type;

   typedef struct packed {
      logic [7:0] occupancy;
      logic [1:0] pass_event;
      logic       alarm_seen;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  occupancy_limit;
      logic [15:0] pass_timeout_ms;
   } cfg_type;

endpackage

/* sv/dual_beam_direction_counter_core.sv */
// ----------------------------------------------------------------------------
// dual_beam_direction_counter_core
// Two-beam people counter: entry/exit detection with timeout window,
// saturating occupancy count and sticky over-limit alarm.
// ----------------------------------------------------------------------------
//  port group   role              handshake
//  req_*        sample / preset   req_valid, req_stall (driven here)
//  rsp_*        one result/item   rsp_valid, rsp_stall (driven by sink)
//  p*           register access   APB, pready tied high
//
//  Two registers: input register, then result register.
//  One item per cycle sustained while rsp_stall is low; the pass state
//  updates as an item moves from the input register into the result register.
//  Reset clears valids, pass state, count and registers to defaults.
//  A stalled result holds; req_stall rises only when both stages are full.
// ----------------------------------------------------------------------------
module dual_beam_direction_counter_core
   import dbdc_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   cfg_type cfg;
   req_type item_ff;
   logic    item_valid_ff, item_valid_in;
   rsp_type result;
   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    advance;
   logic    out_free;

   dbdc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dbdc_tracker #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_tracker (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = item_valid_ff && out_free;
   assign req_stall = item_valid_ff && !out_free;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (!req_stall) begin
         item_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* sv/dbdc_csr.sv */
// ----------------------------------------------------------------------------
// dbdc_csr
// APB register file: occupancy limit and pass timeout.
// ----------------------------------------------------------------------------
module dbdc_csr
   import dbdc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   logic [7:0]  limit_ff;
   logic [7:0]  limit_in;
   logic [15:0] timeout_ff;
   logic [15:0] timeout_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      limit_in   = limit_ff;
      timeout_in = timeout_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_LIMIT:   limit_in   = pwdata[7:0];
            REG_TIMEOUT: timeout_in = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff   <= LIMIT_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         limit_ff   <= limit_in;
         timeout_ff <= timeout_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_LIMIT:   prdata = {24'd0, limit_ff};
         REG_TIMEOUT: prdata = {16'd0, timeout_ff};
         default:     prdata = 32'd0;
      endcase
   end

   assign cfg.occupancy_limit = limit_ff;
   assign cfg.pass_timeout_ms = timeout_ff;

endmodule

/* sv/dbdc_tracker.sv */
// ----------------------------------------------------------------------------
// dbdc_tracker
// Pass detection state and count; computes one result per item.
// ----------------------------------------------------------------------------
module dbdc_tracker
   import dbdc_pkg::*;
#(
   parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   localparam int unsigned WIDE = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   phase_type              phase_ff, phase_in;
   logic [31:0]            start_ff, start_in;
   logic [COUNT_WIDTH-1:0] people_ff, people_in;
   logic                   over_ff, over_in;
   event_type              ev;

   logic [31:0]   elapsed;
   logic          expired;
   logic [WIDE-1:0] preset_w;
   logic [WIDE-1:0] people_w;

   assign elapsed  = item.now_ms - start_ff;
   assign expired  = elapsed > {16'd0, cfg.pass_timeout_ms};
   assign preset_w = WIDE'(item.preset_count);

   always_comb begin
      phase_in  = phase_ff;
      start_in  = start_ff;
      people_in = people_ff;
      over_in   = over_ff;
      ev        = EV_NONE;
      if (item.command) begin
         people_in = (preset_w > WIDE'(COUNT_MAX)) ? COUNT_MAX
                                                  : COUNT_WIDTH'(preset_w);
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               if (item.beam_a) begin
                  start_in = item.now_ms;
                  phase_in = PH_OUTER;
               end else if (item.beam_b) begin
                  start_in = item.now_ms;
                  phase_in = PH_INNER;
               end
            end
            PH_OUTER: begin
               if (expired) begin
                  phase_in = PH_IDLE;
               end else if (item.beam_b) begin
                  if (people_ff != COUNT_MAX) begin
                     people_in = people_ff + 1'b1;
                  end
                  if (WIDE'(people_in) > WIDE'(cfg.occupancy_limit)) begin
                     ev      = EV_OVER;
                     over_in = 1'b1;
                  end else begin
                     ev = EV_ENTRY;
                  end
                  phase_in = PH_CLEAR;
               end
            end
            PH_INNER: begin
               if (expired) begin
                  phase_in = PH_IDLE;
               end else if (item.beam_a) begin
                  if (people_ff != '0) begin
                     people_in = people_ff - 1'b1;
                     ev        = EV_EXIT;
                  end
                  phase_in = PH_CLEAR;
               end
            end
            PH_CLEAR: begin
               if (!item.beam_a && !item.beam_b) begin
                  phase_in = PH_IDLE;
               end
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         start_ff  <= '0;
         people_ff <= '0;
         over_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         start_ff  <= start_in;
         people_ff <= people_in;
         over_ff   <= over_in;
      end
   end

   assign people_w          = WIDE'(people_in);
   assign result.occupancy  = people_w[7:0];
   assign result.pass_event = ev;
   assign result.alarm_seen = over_in;

endmodule

/* verif/dbdc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbdc_checker
// Watches the sample, result and register ports of the two-beam counter,
// keeps its own copy of the pass state and settings, predicts one result
// per accepted item and compares every delivered result in order.
// ----------------------------------------------------------------------------
module dbdc_checker
   import dbdc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  req_type                   req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  rsp_type                   rsp_data,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   input  logic                      pready,
   output int                        fail_count,
   output int                        pending
);

   localparam int unsigned PEOPLE_MAX = (1 << COUNT_WIDTH_DEF) - 1;

   logic [7:0]  limit_cfg;
   logic [15:0] timeout_cfg;
   phase_type   door_phase;
   logic [31:0] window_t0;
   int unsigned headcount;
   logic        alarm_latched;
   rsp_type     occupancy_reports[$];
   rsp_type     want;

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fail_count++;
   endtask

   function automatic rsp_type advance_counter(input req_type smp);
      event_type   ev;
      logic [31:0] elapsed;
      rsp_type     r;
      ev = EV_NONE;
      elapsed = smp.now_ms - window_t0;
      if (smp.command) begin
         headcount = (smp.preset_count > PEOPLE_MAX) ? PEOPLE_MAX : smp.preset_count;
      end else begin
         case (door_phase)
            PH_IDLE: begin
               // outer beam wins when both break together
               if (smp.beam_a) begin
                  window_t0 = smp.now_ms;
                  door_phase = PH_OUTER;
               end else if (smp.beam_b) begin
                  window_t0 = smp.now_ms;
                  door_phase = PH_INNER;
               end
            end
            PH_OUTER: begin
               if (elapsed > {16'd0, timeout_cfg}) begin
                  door_phase = PH_IDLE;
               end else if (smp.beam_b) begin
                  if (headcount < PEOPLE_MAX)
                     headcount++;
                  if (headcount > limit_cfg) begin
                     ev = EV_OVER;
                     alarm_latched = 1'b1;
                  end else begin
                     ev = EV_ENTRY;
                  end
                  door_phase = PH_CLEAR;
               end
            end
            PH_INNER: begin
               if (elapsed > {16'd0, timeout_cfg}) begin
                  door_phase = PH_IDLE;
               end else if (smp.beam_a) begin
                  if (headcount > 0) begin
                     headcount--;
                     ev = EV_EXIT;
                  end
                  door_phase = PH_CLEAR;
               end
            end
            default: begin
               if (!smp.beam_a && !smp.beam_b)
                  door_phase = PH_IDLE;
            end
         endcase
      end
      r.occupancy  = headcount[7:0];
      r.pass_event = ev;
      r.alarm_seen = alarm_latched;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         limit_cfg     = LIMIT_RESET;
         timeout_cfg   = TIMEOUT_RESET;
         door_phase    = PH_IDLE;
         window_t0     = '0;
         headcount     = 0;
         alarm_latched = 1'b0;
         fail_count    = 0;
         occupancy_reports.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == {REG_LIMIT, 2'b00})
               limit_cfg = pwdata[7:0];
            else if (paddr == {REG_TIMEOUT, 2'b00})
               timeout_cfg = pwdata[15:0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (occupancy_reports.size() == 0) begin
               report_mismatch($sformatf("result %h with none expected", rsp_data));
            end else begin
               want = occupancy_reports.pop_front();
               if (rsp_data.occupancy !== want.occupancy)
                  report_mismatch($sformatf("occupancy %0d, expected %0d",
                                            rsp_data.occupancy, want.occupancy));
               if (rsp_data.pass_event !== want.pass_event)
                  report_mismatch($sformatf("pass_event %0d, expected %0d",
                                            rsp_data.pass_event, want.pass_event));
               if (rsp_data.alarm_seen !== want.alarm_seen)
                  report_mismatch($sformatf("alarm_seen %0b, expected %0b",
                                            rsp_data.alarm_seen, want.alarm_seen));
            end
         end
         if (req_valid && !req_stall)
            occupancy_reports.push_back(advance_counter(req_data));
      end
      pending = occupancy_reports.size();
   end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the two-beam counter: directed passes, presets, expired
// windows and time wrap, then random crossing sequences over several
// limit/timeout settings with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top
   import dbdc_pkg::*;
();

   localparam int unsigned HOLD_CYCLES = 80;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_type                   rsp_data;
   logic                      psel      = 1'b0;
   logic                      penable   = 1'b0;
   logic                      pwrite    = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr     = '0;
   logic [31:0]               pwdata    = '0;
   logic [31:0]               prdata;
   logic                      pready;
   int                        fail_count;
   int                        pending;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned items_sent     = 0;
   logic        hold_go        = 1'b0;
   logic        long_hold      = 1'b0;
   logic [7:0]  cur_limit      = LIMIT_RESET;
   int unsigned cur_timeout    = TIMEOUT_RESET;
   logic [31:0] ms_now         = 32'd10000;

   int unsigned limit_plan   [8] = '{0, 255, 3, 2, 0, 1, 254, 5};
   int unsigned timeout_plan [8] = '{0, 65535, 1, 50, 0, 300, 65534, 2000};
   int unsigned idle_plan    [4] = '{0, 54, 0, 33};
   int unsigned stall_plan   [4] = '{0, 0, 54, 33};

   dual_beam_direction_counter_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   dbdc_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
   end

   // long receiver hold-off, so the block fills and stalls its input
   initial begin
      wait (hold_go);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic req_type poll(input logic a, input logic b, input logic [31:0] t);
      req_type r;
      r.command      = 1'b0;
      r.beam_a       = a;
      r.beam_b       = b;
      r.now_ms       = t;
      r.preset_count = 8'($urandom);
      return r;
   endfunction

   function automatic req_type preset(input logic [7:0] n);
      req_type r;
      r = poll(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
      r.command      = 1'b1;
      r.preset_count = n;
      return r;
   endfunction

   function automatic logic [7:0] pick_count();
      case ($urandom_range(4))
         0:       return 8'd0;
         1:       return $urandom_range(1) ? 8'd255 : 8'd254;
         2, 3:    return cur_limit - 8'($urandom_range(2));
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_item(input req_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_WIDTH-1:0] addr, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned stop_at;
      int unsigned span;
      int unsigned roll;
      logic [31:0] t0;
      logic        outer_first;
      logic        together;
      req_type     r;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         roll = $urandom_range(99);
         if (roll < 10) begin
            send_item(preset(pick_count()));
         end else if (roll < 25) begin
            r = poll(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
            r.command = ($urandom_range(3) == 0);
            send_item(r);
         end else begin
            outer_first = 1'($urandom_range(1));
            together    = ($urandom_range(9) == 0);
            case ($urandom_range(9))
               0:       span = cur_timeout;
               1:       span = cur_timeout + 1 + $urandom_range(cur_timeout);
               default: span = $urandom_range(cur_timeout);
            endcase
            if ($urandom_range(9) == 0)
               ms_now = 32'hFFFF_FFFF - $urandom_range(cur_timeout);
            if ($urandom_range(1)) begin
               ms_now += $urandom_range(50);
               send_item(poll(1'b0, 1'b0, ms_now));
            end
            t0 = ms_now;
            send_item(poll(outer_first | together, !outer_first | together, t0));
            repeat ($urandom_range(2))
               send_item(poll(outer_first, !outer_first, t0 + 32'(span / 2)));
            ms_now = t0 + 32'(span);
            if ($urandom_range(2) == 0)
               send_item(poll(!outer_first, outer_first, ms_now));
            else
               send_item(poll(1'b1, 1'b1, ms_now));
            repeat ($urandom_range(2)) begin
               ms_now += $urandom_range(50);
               send_item(poll(1'($urandom_range(1)), 1'($urandom_range(1)), ms_now));
            end
            ms_now += 1 + $urandom_range(50);
            send_item(poll(1'b0, 1'b0, ms_now));
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: defaults, limit 5 and timeout 2000
      send_item(preset(8'd0));
      send_item(poll(1'b0, 1'b1, 32'd100));          // inner window
      send_item(poll(1'b1, 1'b1, 32'd200));          // exit at zero
      send_item(poll(1'b0, 1'b0, 32'd300));
      send_item(poll(1'b1, 1'b1, 32'd1000));         // both together: outer wins
      send_item(poll(1'b1, 1'b1, 32'd1000));         // entry
      send_item(poll(1'b0, 1'b0, 32'd1010));
      send_item(poll(1'b1, 1'b0, 32'd5000));
      send_item(poll(1'b0, 1'b1, 32'd7001));         // expired, no new window
      send_item(poll(1'b0, 1'b1, 32'd7002));
      send_item(poll(1'b1, 1'b1, 32'd9002));         // exit at window edge
      send_item(poll(1'b0, 1'b0, 32'd9003));
      send_item(preset(8'd255));
      send_item(poll(1'b1, 1'b0, 32'hFFFF_FF00));    // window across time wrap
      send_item(poll(1'b0, 1'b1, 32'h0000_0100));    // entry at full count: over limit
      send_item(poll(1'b0, 1'b0, 32'h0000_0200));
      send_item(preset(8'd4));
      send_item(poll(1'b1, 1'b0, 32'd50));
      send_item(poll(1'b1, 1'b1, 32'd2050));         // entry up to the limit
      send_item(poll(1'b0, 1'b0, 32'd2060));
      send_item(preset(8'd5));
      send_item(poll(1'b1, 1'b0, 32'd3000));
      send_item(poll(1'b0, 1'b1, 32'd3001));         // entry over limit
      send_item(poll(1'b0, 1'b0, 32'hFFFF_FFFF));

      for (int p = 0; p < 8; p++) begin
         wait_drained();
         cur_limit   = 8'(limit_plan[p]);
         cur_timeout = timeout_plan[p];
         if (p == 4) begin
            cur_limit   = 8'($urandom);
            cur_timeout = $urandom_range(65535, 1);
         end
         csr_write({REG_LIMIT, 2'b00}, 32'(cur_limit));
         csr_write({REG_TIMEOUT, 2'b00}, 32'(cur_timeout));
         send_idle_pct  = idle_plan[p % 4];
         recv_stall_pct = stall_plan[p % 4];
         run_random(48);
      end

      wait_drained();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_go        = 1'b1;
      run_random(30);

      wait_drained();
      repeat (4) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* sim.f */
sv/dbdc_pkg.sv
sv/dbdc_csr.sv
sv/dbdc_tracker.sv
sv/dual_beam_direction_counter_core.sv
verif/dbdc_checker.sv
verif/tb_top.sv
